### rtl/core/fmbs_pkg.sv
// Package for the FM-index backward search step.
// Item field widths and item kind codes; no dependencies.
`default_nettype none
package fmbs_pkg;
  localparam int ROW_W  = 16;
  localparam int SYM_W  = 3;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXTEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;
endpackage
`default_nettype wire

### rtl/core/fm_index_backward_search_step.sv
// FM-index backward search step: BWT store, checkpoint store and rank engine.
// Depends on fmbs_pkg for field widths and item kind codes.
`default_nettype none
// The block holds the BWT of a DNA sequence in one synchronous memory and a
// row of per-base occurrence counts every CHECKPOINT_GAP positions in a
// second one. A load item is handled in the idle state: it writes the
// symbol, bumps the count of its base, if it is one, and, at the start of
// each gap, writes a checkpoint row. A full-range item passes through the
// start, rows and output states, and the block takes the next item once
// its result is in the output register. An extend item of a base needs
// two ranks. A rank finds the checkpoint of its row by a reciprocal
// multiplication and a remainder step, reads the nearer written checkpoint
// and then scans the BWT memory one entry a cycle between that checkpoint
// and the row. Ranks past the loaded length or below row zero skip all of
// this and are settled in the rank state. The scan covers at most half a
// gap when the nearer checkpoint is used, and up to almost a whole gap near
// the end of the loaded part, where the later checkpoint does not exist
// yet. Items are handled one at a time; a finished result waits in the
// output register while the next item is taken. Neither memory is cleared
// after reset; entries never written are never read.
module fm_index_backward_search_step
  import fmbs_pkg::*;
#(
  parameter int MAX_LEN        = 65536,
  parameter int CHECKPOINT_GAP = 128,
  parameter int ALPHABET       = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [SYM_W-1:0]  symbol,
  input  wire logic [ROW_W-1:0]  range_start,
  input  wire logic [ROW_W-1:0]  range_end,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   found,
  output logic [ROW_W-1:0]       out_start,
  output logic [ROW_W-1:0]       out_end
);
  localparam int LW   = $clog2(MAX_LEN + 1);
  localparam int CW   = LW;
  localparam int XW   = (LW > ROW_W) ? LW : ROW_W;
  localparam int AW   = $clog2(MAX_LEN);
  localparam int CPN  = MAX_LEN / CHECKPOINT_GAP + 1;
  localparam int SW   = $clog2(CPN);
  localparam int BW   = $clog2(ALPHABET);
  localparam int RW   = $clog2(CHECKPOINT_GAP) + 1;
  localparam int ACW  = $clog2(CHECKPOINT_GAP + 1);
  localparam int GPW  = (CHECKPOINT_GAP > 1) ? $clog2(CHECKPOINT_GAP) : 1;

  // Row divided by the gap as (row * DIV_M) >> DIV_S, exact for 16-bit rows.
  localparam int DIV_S = ROW_W + $clog2(CHECKPOINT_GAP);
  localparam logic [ROW_W:0] DIV_M = (ROW_W + 1)'(((64'd1 << DIV_S) +
      64'(CHECKPOINT_GAP) - 64'd1) / 64'(CHECKPOINT_GAP));

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_RANK  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_PLAN  = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_ROWS  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_REM   = 4'd8;

  typedef logic [ALPHABET-1:0][CW-1:0] cp_row_t;

  // Memories.
  logic [SYM_W-1:0] bwt_mem [MAX_LEN];
  cp_row_t          cp_mem  [CPN];
  logic [SYM_W-1:0] bwt_q;
  cp_row_t          cp_q;

  // Index state.
  cp_row_t          counts;
  cp_row_t          counts_next;
  logic [LW-1:0]    len;
  logic [GPW-1:0]   gphase;
  logic [SW-1:0]    slot;

  // Item and rank engine state.
  logic [3:0]       state;
  logic [KIND_W-1:0] kind_r;
  logic [SYM_W-1:0] sym_r;
  logic [BW-1:0]    b_r;
  logic             sym_ok;
  logic             phase;
  logic [ROW_W-1:0] rs_r;
  logic [ROW_W-1:0] re_r;
  logic [ROW_W-1:0] p;
  logic [ROW_W-1:0] q;
  logic [RW-1:0]    rem;
  logic             later;
  logic [AW-1:0]    scan_addr;
  logic [RW-1:0]    scan_cnt;
  logic             rd_v;
  logic [ACW-1:0]   acc;
  logic [CW-1:0]    lo;
  logic [CW-1:0]    hi;
  logic [LW:0]      f;

  logic             in_acc;
  logic             do_load;
  logic             sym_in_ok;
  logic [ROW_W-1:0] p_sel;
  logic             rank_zero;
  logic             rank_short;
  logic             rank_done;
  logic [CW-1:0]    rank_val;
  logic [2*ROW_W:0] div_prod;
  logic [ROW_W-1:0] q_c;
  logic [RW-1:0]    rem_c;
  logic             later_c;
  logic [XW:0]      cp_far;
  logic [XW-1:0]    slot_x;
  logic [XW-1:0]    start_x;
  logic             bwt_rd_en;
  logic [LW:0]      f_c;
  logic [LW:0]      st_sum;
  logic [LW:0]      en_sum;
  logic             res_found;

  function automatic logic [ROW_W-1:0] sat_row(input logic [LW:0] v);
    logic [XW:0] vx;
    vx = (XW + 1)'(v);
    sat_row = (vx > (XW + 1)'(2 ** ROW_W - 1)) ? {ROW_W{1'b1}} : ROW_W'(vx);
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign sym_in_ok = ({1'b0, symbol} < (SYM_W + 1)'(ALPHABET));
  assign do_load   = in_acc && (kind == KIND_LOAD) && (len < LW'(MAX_LEN));

  always_comb begin
    counts_next = counts;
    if (sym_in_ok) begin
      counts_next[symbol[BW-1:0]] = counts[symbol[BW-1:0]] + CW'(1);
    end
  end

  // Rank set-up: row below zero gives zero, rows past the end give the total.
  assign p_sel      = phase ? re_r : (rs_r - ROW_W'(1));
  assign rank_zero  = !phase && (rs_r == '0);
  assign rank_short = rank_zero || (XW'(p_sel) >= XW'(len));

  // Quotient of the row by the gap is registered in the divide state, the remainder in the state after it.
  assign div_prod = (2 * ROW_W + 1)'(p) * (2 * ROW_W + 1)'(DIV_M);
  assign q_c      = ROW_W'(div_prod >> DIV_S);
  assign rem_c    = RW'(p - ROW_W'(q * ROW_W'(CHECKPOINT_GAP)));

  // Use the later checkpoint when it is strictly nearer and already written.
  assign cp_far  = (XW + 1)'(p) - (XW + 1)'(rem) + (XW + 1)'(CHECKPOINT_GAP);
  assign later_c = ({rem, 1'b0} > (RW + 1)'(CHECKPOINT_GAP)) &&
                   (cp_far < (XW + 1)'(len));
  assign slot_x  = XW'(q) + (later_c ? XW'(1) : XW'(0));
  assign start_x = later_c ? (XW'(p) + XW'(1)) : (XW'(p) - XW'(rem) + XW'(1));

  assign bwt_rd_en = (state == S_SCAN) && (scan_cnt != '0);

  always_comb begin
    rank_done = 1'b0;
    rank_val  = '0;
    if (state == S_RANK && rank_short) begin
      rank_done = 1'b1;
      rank_val  = rank_zero ? '0 : counts[b_r];
    end else if (state == S_SCAN && scan_cnt == '0 && !rd_v) begin
      rank_done = 1'b1;
      rank_val  = later ? (cp_q[b_r] - CW'(acc)) : (cp_q[b_r] + CW'(acc));
    end
  end

  always_comb begin
    f_c = (LW + 1)'(1);
    for (int i = 0; i < ALPHABET; i++) begin
      if (BW'(i) < b_r) begin
        f_c = f_c + (LW + 1)'(counts[i]);
      end
    end
  end

  assign res_found = (lo < hi);
  assign st_sum    = f + (LW + 1)'(lo);
  assign en_sum    = f + (LW + 1)'(hi) - (LW + 1)'(1);

  // BWT memory: written by loads, read by the scan.
  always_ff @(posedge clk) begin
    if (do_load) begin
      bwt_mem[AW'(len)] <= symbol;
    end
    if (bwt_rd_en) begin
      bwt_q <= bwt_mem[scan_addr];
    end
  end

  // Checkpoint memory: one row of counts per gap.
  always_ff @(posedge clk) begin
    if (do_load && gphase == '0) begin
      cp_mem[slot] <= counts_next;
    end
    if (state == S_PLAN) begin
      cp_q <= cp_mem[SW'(slot_x)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
      len    <= '0;
      gphase <= '0;
      slot   <= '0;
    end else if (do_load) begin
      counts <= counts_next;
      len    <= len + LW'(1);
      if (gphase == '0) begin
        slot <= slot + SW'(1);
      end
      if (gphase == GPW'(CHECKPOINT_GAP - 1)) begin
        gphase <= '0;
      end else begin
        gphase <= gphase + GPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_v      <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      rd_v <= bwt_rd_en;
      case (state)
        S_IDLE: begin
          if (in_acc && (kind == KIND_EXTEND || kind == KIND_FULL)) begin
            state <= S_START;
          end
        end
        S_START: begin
          if (!sym_ok || kind_r == KIND_FULL) begin
            state <= S_ROWS;
          end else begin
            state <= S_RANK;
          end
        end
        S_RANK: begin
          if (rank_done) begin
            state <= phase ? S_ROWS : S_RANK;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: state <= S_REM;
        S_REM: state <= S_PLAN;
        S_PLAN: state <= S_SCAN;
        S_SCAN: begin
          if (rank_done) begin
            state <= phase ? S_ROWS : S_RANK;
          end
        end
        S_ROWS: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= kind;
      sym_r  <= symbol;
      b_r    <= symbol[BW-1:0];
      sym_ok <= sym_in_ok;
      rs_r   <= range_start;
      re_r   <= range_end;
    end
    case (state)
      S_START: begin
        phase <= 1'b0;
        lo    <= '0;
        if (!sym_ok) begin
          hi <= '0;
        end else begin
          hi <= counts[b_r];
        end
      end
      S_RANK: begin
        p <= p_sel;
      end
      S_DIV: begin
        q <= q_c;
      end
      S_REM: begin
        rem <= rem_c;
      end
      S_PLAN: begin
        later     <= later_c;
        scan_addr <= AW'(start_x);
        scan_cnt  <= later_c ? (RW'(CHECKPOINT_GAP) - rem) : rem;
        acc       <= '0;
      end
      S_SCAN: begin
        if (bwt_rd_en) begin
          scan_addr <= scan_addr + AW'(1);
          scan_cnt  <= scan_cnt - RW'(1);
        end
        if (rd_v && bwt_q == sym_r) begin
          acc <= acc + ACW'(1);
        end
      end
      S_ROWS: f <= f_c;
      S_OUT: begin
        if (!out_valid || out_ready) begin
          found     <= res_found;
          out_start <= res_found ? sat_row(st_sum) : '0;
          out_end   <= res_found ? sat_row(en_sum) : '0;
        end
      end
      default: begin
      end
    endcase
    if (rank_done) begin
      if (phase) begin
        hi <= rank_val;
      end else begin
        lo    <= rank_val;
        phase <= 1'b1;
      end
    end
  end

  // An empty result always carries zero rows.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (out_start == '0 && out_end == '0))
    else $error("empty result with non-zero rows");

  // A non-empty result is an ordered range.
  a_range_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (out_start <= out_end))
    else $error("result range out of order");

  // Accepted extend items leave the idle state on the next cycle.
  a_extend_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == KIND_EXTEND) |=> (state != S_IDLE))
    else $error("extend item dropped");

  // The loaded length never passes the store depth.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(MAX_LEN))
    else $error("loaded length past store depth");
endmodule
`default_nettype wire

### bench/tb_fm_index_backward_search_step.sv
// Self-checking bench for the FM-index backward search step.
// Depends on fmbs_pkg and fm_index_backward_search_step; a scoreboard class predicts results.
`timescale 1ns / 1ps

module tb_fm_index_backward_search_step;
  import fmbs_pkg::*;

  localparam int MAX_LEN  = 65536;
  localparam int GAP      = 128;
  localparam int BASES    = 4;
  localparam int ROW_LIM  = 65535;

  typedef struct {
    logic            found;
    logic [ROW_W-1:0] first;
    logic [ROW_W-1:0] last;
  } range_t;

  // Scoreboard: a private copy of the index, the rank arithmetic and the queue
  // of ranges still to come out of the block.
  class fm_scoreboard;
    logic [SYM_W-1:0] bwt [MAX_LEN];
    int unsigned      marks [MAX_LEN/GAP + 1][BASES];
    int unsigned      totals [BASES];
    int unsigned      length;
    int unsigned      phase;
    range_t           pending [$];
    range_t           latest;
    int               errors;

    function new();
      for (int b = 0; b < BASES; b++) totals[b] = 0;
      length = 0;
      phase = 0;
      errors = 0;
      latest = '{1'b0, '0, '0};
    endfunction

    // Occurrences of base b in bwt[0..p], p below the loaded length.
    function int unsigned occ(int unsigned b, int unsigned p);
      int unsigned mark;
      int unsigned n;
      mark = (p / GAP) * GAP;
      if (p - mark > (mark + GAP) - p && mark + GAP < length) mark += GAP;
      n = marks[mark / GAP][b];
      if (mark > p) begin
        for (int unsigned i = p + 1; i <= mark; i++) if (bwt[i] == b) n--;
      end else begin
        for (int unsigned i = p; i > mark; i--) if (bwt[i] == b) n++;
      end
      return n;
    endfunction

    function int unsigned occ_sat(int unsigned b, int unsigned p);
      if (p >= length) return totals[b];
      return occ(b, p);
    endfunction

    function logic [ROW_W-1:0] clip(int unsigned v);
      return (v > ROW_LIM) ? ROW_W'(ROW_LIM) : ROW_W'(v);
    endfunction

    function void note(logic [KIND_W-1:0] k, logic [SYM_W-1:0] s,
                       logic [ROW_W-1:0] rs, logic [ROW_W-1:0] re);
      range_t r;
      int unsigned f;
      int unsigned lo;
      int unsigned hi;
      r = '{1'b0, '0, '0};
      if (k == KIND_LOAD) begin
        if (length >= MAX_LEN) return;
        bwt[length] = s;
        if (s < BASES) totals[s]++;
        if (phase == 0)
          for (int b = 0; b < BASES; b++) marks[length / GAP][b] = totals[b];
        phase++;
        if (phase >= GAP) phase = 0;
        length++;
        return;
      end
      if (k == KIND_NONE) return;
      if (s < BASES) begin
        f = 1;
        for (int b = 0; b < s; b++) f += totals[b];
        if (k == KIND_FULL) begin
          if (totals[s] > 0) r = '{1'b1, clip(f), clip(f + totals[s] - 1)};
        end else begin
          lo = (rs == 0) ? 0 : occ_sat(s, rs - 1);
          hi = occ_sat(s, re);
          if (lo < hi) r = '{1'b1, clip(f + lo), clip(f + hi - 1)};
        end
      end
      pending.push_back(r);
      latest = r;
    endfunction

    function void check(logic fd, logic [ROW_W-1:0] st, logic [ROW_W-1:0] en);
      range_t e;
      if (pending.size() == 0) begin
        $error("unexpected result found=%0d out_start=%0d out_end=%0d", fd, st, en);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (fd !== e.found) begin
        $error("found expected %0d actual %0d", e.found, fd);
        errors++;
      end
      if (st !== e.first) begin
        $error("out_start expected %0d actual %0d", e.first, st);
        errors++;
      end
      if (en !== e.last) begin
        $error("out_end expected %0d actual %0d", e.last, en);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [KIND_W-1:0] kind;
  logic [SYM_W-1:0]  symbol;
  logic [ROW_W-1:0]  range_start;
  logic [ROW_W-1:0]  range_end;
  logic              out_valid;
  logic              out_ready;
  logic              found;
  logic [ROW_W-1:0]  out_start;
  logic [ROW_W-1:0]  out_end;

  fm_scoreboard sb;
  bit quiet;          // set for the last part of the run: no idling on either side
  int hold_cycles;    // a request to the receiver for one long hold-off

  fm_index_backward_search_step u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .symbol(symbol), .range_start(range_start), .range_end(range_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .found(found), .out_start(out_start), .out_end(out_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Both monitors sample at the rising edge, before any nonblocking update of
  // that edge lands, so they see exactly the values the block saw.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note(kind, symbol, range_start, range_end);
    if (!rst && out_valid && out_ready) sb.check(found, out_start, out_end);
  end

  // Receiver. Idles in short random bursts, or once for a long stretch when the
  // main process asks, so that the block backs up and stalls its input.
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one item and returns in the time step at which it is taken. An idle
  // burst may come first; in_valid is only lowered there, never in a step in
  // which it is raised again.
  task automatic send(logic [KIND_W-1:0] k, logic [SYM_W-1:0] s,
                      logic [ROW_W-1:0] rs, logic [ROW_W-1:0] re);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    symbol      <= s;
    range_start <= rs;
    range_end   <= re;
    do @(posedge clk); while (!in_ready);
  endtask

  // The last item was noted at the edge send returned on, so the queue is
  // only looked at from the following edge on.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol();
    if ($urandom_range(0, 7) == 0) return SYM_W'($urandom_range(4, 7));
    return SYM_W'($urandom_range(0, 3));
  endfunction

  // One random item. Most extends follow a backward search: they narrow the
  // range the previous search item produced, restarting from a full-range item
  // once a search runs empty. The rest are random rows, inside or outside the
  // loaded part, and a few loads and ignored kinds.
  task automatic random_item(bit with_loads);
    int unsigned sel;
    int unsigned lim;
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] z;
    sel = $urandom_range(0, 99);
    lim = sb.length + 4;
    if (with_loads && sel < 20) begin
      send(KIND_LOAD, pick_symbol(), ROW_W'($urandom), ROW_W'($urandom));
    end else if (sel < 24) begin
      send(KIND_NONE, SYM_W'($urandom), ROW_W'($urandom), ROW_W'($urandom));
    end else if (sel < 36 || !sb.latest.found && sel < 50) begin
      send(KIND_FULL, pick_symbol(), ROW_W'($urandom), ROW_W'($urandom));
    end else if (sel < 75 && sb.latest.found) begin
      send(KIND_EXTEND, pick_symbol(), sb.latest.first, sb.latest.last);
    end else if (sel < 90) begin
      a = ROW_W'($urandom_range(0, lim > ROW_LIM ? ROW_LIM : lim));
      z = ROW_W'($urandom_range(0, lim > ROW_LIM ? ROW_LIM : lim));
      if (a > z && $urandom_range(0, 3) != 0) send(KIND_EXTEND, pick_symbol(), z, a);
      else send(KIND_EXTEND, pick_symbol(), a, z);
    end else begin
      send(KIND_EXTEND, pick_symbol(), ROW_W'($urandom), ROW_W'($urandom));
    end
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    hold_cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_NONE;
    symbol = '0;
    range_start = '0;
    range_end = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty index: every query comes back empty.
    send(KIND_FULL, 3'd0, '0, '0);
    send(KIND_EXTEND, 3'd3, 16'd0, 16'hFFFF);
    send(KIND_NONE, 3'd7, 16'hFFFF, 16'hFFFF);

    // A few hundred symbols, a sentinel among them, so several checkpoints exist.
    send(KIND_LOAD, 3'd4, '0, '0);
    for (int i = 0; i < 300; i++) send(KIND_LOAD, pick_symbol(), '0, '0);
    drain();

    // Directed queries: every base, range start zero, rows past the loaded
    // length, start after end, non-base symbols and the ignored kind.
    for (int b = 0; b < BASES; b++) send(KIND_FULL, SYM_W'(b), '0, '0);
    send(KIND_FULL, 3'd5, '0, '0);
    send(KIND_EXTEND, 3'd0, 16'd0, 16'd0);
    send(KIND_EXTEND, 3'd1, 16'd0, 16'hFFFF);
    send(KIND_EXTEND, 3'd2, 16'd450, 16'hFFFF);
    send(KIND_EXTEND, 3'd3, 16'd200, 16'd100);
    send(KIND_EXTEND, 3'd6, 16'd1, 16'd300);
    send(KIND_EXTEND, 3'd2, 16'd63, 16'd64);
    send(KIND_EXTEND, 3'd1, 16'd129, 16'd383);
    send(KIND_EXTEND, 3'd0, 16'd191, 16'd192);
    send(KIND_NONE, 3'd0, 16'd5, 16'd9);
    drain();

    // Long receiver hold-off while items keep coming, then a sender pause
    // until every expected range has been seen.
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) random_item(1'b0);
    drain();

    for (int i = 0; i < 150; i++) begin
      random_item(1'b1);
      if (i == 70) drain();
    end
    drain();

    // Last part without idling: queries over the whole loaded index.
    quiet = 1'b1;
    for (int b = 0; b < BASES; b++) send(KIND_FULL, SYM_W'(b), '0, '0);
    send(KIND_EXTEND, 3'd3, 16'd0, 16'hFFFF);
    send(KIND_EXTEND, 3'd3, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 30; i++) random_item(1'b0);
    drain();
    repeat (400) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_fm_index_backward_search_step passed");
    end else begin
      if (sb.pending.size() != 0) $error("%0d expected ranges never arrived", sb.pending.size());
      $display("tb_fm_index_backward_search_step failed");
    end
    $finish;
  end

  // Watchdog, well above the slowest correct run.
  initial begin
    #20ms;
    $display("tb_fm_index_backward_search_step failed");
    $finish;
  end

endmodule

### fm_index_backward_search_step.f
rtl/core/fmbs_pkg.sv
rtl/core/fm_index_backward_search_step.sv
bench/tb_fm_index_backward_search_step.sv
